[rtl/core/mlc_pkg.sv]
// shared types and constants of the markdown line classifier
package mlc_pkg;

  localparam int unsigned SpaceW = 13;
  localparam int unsigned SpaceFieldMax = 8191;

  localparam logic [7:0] ChSpace    = 8'h20;
  localparam logic [7:0] ChBlankTop = 8'hfe;
  localparam logic [7:0] ChFormFeed = 8'h0c;
  localparam logic [7:0] ChStar     = 8'h2a;
  localparam logic [7:0] ChDash     = 8'h2d;
  localparam logic [7:0] ChUnder    = 8'h5f;
  localparam logic [1:0] RuleMin    = 2'd3;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       has_byte;
    logic       end_of_line;
  } mlc_item_t;

  typedef struct packed {
    logic [SpaceW-1:0] leading_spaces;
    logic [7:0]        first_non_space;
    logic              blank_line;
    logic              horizontal_rule;
  } mlc_result_t;

  function automatic logic is_rule_byte(logic [7:0] c);
    return (c == ChStar) || (c == ChDash) || (c == ChUnder);
  endfunction

endpackage

[rtl/core/mlc_if.sv]
// stream interfaces for line bytes in and line results out
interface mlc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;
  logic       has_byte;
  logic       end_of_line;

  modport source (output valid, output line_byte, output has_byte, output end_of_line,
                  input ready);
  modport sink (input valid, input line_byte, input has_byte, input end_of_line,
                output ready);
endinterface

interface mlc_out_if;
  logic        valid;
  logic        ready;
  logic [12:0] leading_spaces;
  logic [7:0]  first_non_space;
  logic        blank_line;
  logic        horizontal_rule;

  modport source (output valid, output leading_spaces, output first_non_space,
                  output blank_line, output horizontal_rule, input ready);
  modport sink (input valid, input leading_spaces, input first_non_space,
                input blank_line, input horizontal_rule, output ready);
endinterface

[rtl/core/mlc_in_stage.sv]
// input register holding one accepted byte word
module mlc_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mlc_pkg::mlc_item_t in_item_i,
  input  logic               take_i,
  output logic               item_vld_o,
  output mlc_pkg::mlc_item_t item_o
);
  import mlc_pkg::*;

  logic      vld_q, vld_d;
  mlc_item_t item_q;

  assign in_ready_o = !vld_q || take_i;
  assign vld_d      = in_ready_o ? in_valid_i : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  assign item_vld_o = vld_q;
  assign item_o     = item_q;

endmodule

[rtl/core/mlc_line_acc.sv]
// per-line state and classification of the current line
module mlc_line_acc #(
  parameter int unsigned MAX_LINE_LEN = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 take_i,
  input  mlc_pkg::mlc_item_t   item_i,
  output mlc_pkg::mlc_result_t result_o
);
  import mlc_pkg::*;

  localparam int unsigned SpaceCapI =
    (MAX_LINE_LEN < SpaceFieldMax) ? MAX_LINE_LEN : SpaceFieldMax;
  localparam logic [SpaceW-1:0] SpaceCap = SpaceCapI[SpaceW-1:0];

  logic [SpaceW-1:0] space_cnt_q, space_cnt_d;
  logic              seen_q, seen_d;
  logic [7:0]        first_q, first_d;
  logic              blank_q, blank_d;
  logic [1:0]        rule_cnt_q, rule_cnt_d;
  logic              broken_q, broken_d;
  logic [7:0]        c;
  logic              is_space;

  assign c        = item_i.line_byte;
  assign is_space = (c == ChSpace);

  always_comb begin
    space_cnt_d = space_cnt_q;
    seen_d      = seen_q;
    first_d     = first_q;
    blank_d     = blank_q;
    rule_cnt_d  = rule_cnt_q;
    broken_d    = broken_q;
    if (item_i.has_byte) begin
      if (!is_space && ((c & ChBlankTop) != ChFormFeed)) begin
        blank_d = 1'b0;
      end
      if (!seen_q && is_space) begin
        if (space_cnt_q < SpaceCap) begin
          space_cnt_d = space_cnt_q + 1'b1;
        end
      end else begin
        if (!seen_q) begin
          seen_d  = 1'b1;
          first_d = c;
          if (!is_rule_byte(c)) begin
            broken_d = 1'b1;
          end
        end
        if (c == first_d) begin
          if (rule_cnt_q < RuleMin) begin
            rule_cnt_d = rule_cnt_q + 1'b1;
          end
        end else if (!is_space) begin
          broken_d = 1'b1;
        end
      end
    end
    result_o.leading_spaces  = space_cnt_d;
    result_o.first_non_space = seen_d ? first_d : 8'h00;
    result_o.blank_line      = blank_d;
    result_o.horizontal_rule = seen_d && !broken_d && (rule_cnt_d >= RuleMin) &&
                               is_rule_byte(first_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      space_cnt_q <= '0;
      seen_q      <= 1'b0;
      first_q     <= 8'h00;
      blank_q     <= 1'b1;
      rule_cnt_q  <= 2'd0;
      broken_q    <= 1'b0;
    end else if (take_i) begin
      if (item_i.end_of_line) begin
        space_cnt_q <= '0;
        seen_q      <= 1'b0;
        first_q     <= 8'h00;
        blank_q     <= 1'b1;
        rule_cnt_q  <= 2'd0;
        broken_q    <= 1'b0;
      end else begin
        space_cnt_q <= space_cnt_d;
        seen_q      <= seen_d;
        first_q     <= first_d;
        blank_q     <= blank_d;
        rule_cnt_q  <= rule_cnt_d;
        broken_q    <= broken_d;
      end
    end
  end

  a_clear_after_eol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && item_i.end_of_line |=> space_cnt_q == '0 && !seen_q && blank_q &&
      rule_cnt_q == 2'd0 && !broken_q)
    else $error("line state not cleared after end of line");

  a_rule_needs_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rule_cnt_q != 2'd0 |-> seen_q)
    else $error("rule count without a non-space byte");

  a_space_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    space_cnt_q <= SpaceCap)
    else $error("leading space count above cap");

endmodule

[rtl/core/markdown_line_classifier.sv]
// top level of the markdown line classifier
// usage:
//   in_i carries one byte of a text line per word, with has_byte and
//   end_of_line; a lone word with has_byte low and end_of_line high is an
//   empty line. out_o gives one result word per line: leading space count
//   (saturating at MAX_LINE_LEN or 8191), first non-space byte, blank-line
//   flag and horizontal-rule flag.
// output: a line's result is loaded into the result register as the word
//   ending the line leaves the input register, once any pending result is taken.
// throughput: 1 word per cycle outside stalls; each word updates a few small
//   line registers through one level of byte compares.
// reset: all line state clears, no word is held, no result is pending.
// stall: a held result waits in the result register; bytes inside a line
//   keep flowing, and only a word that ends a line waits in the input
//   register until the pending result is taken, which holds in_i ready low.
module markdown_line_classifier #(
  parameter int unsigned MAX_LINE_LEN = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  mlc_in_if.sink           in_i,
  mlc_out_if.source        out_o
);
  import mlc_pkg::*;

  mlc_item_t   in_item;
  mlc_item_t   item;
  logic        item_vld;
  logic        take;
  mlc_result_t result;
  mlc_result_t out_q;
  logic        out_vld_q, out_vld_d;
  logic        load;

  assign in_item.line_byte   = in_i.line_byte;
  assign in_item.has_byte    = in_i.has_byte;
  assign in_item.end_of_line = in_i.end_of_line;

  mlc_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .in_item_i  (in_item),
    .take_i     (take),
    .item_vld_o (item_vld),
    .item_o     (item)
  );

  assign take = item_vld && (!item.end_of_line || !out_vld_q || out_o.ready);
  assign load = take && item.end_of_line;

  mlc_line_acc #(
    .MAX_LINE_LEN (MAX_LINE_LEN)
  ) u_line_acc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (take),
    .item_i   (item),
    .result_o (result)
  );

  always_comb begin
    out_vld_d = out_vld_q;
    if (load) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= result;
    end
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.leading_spaces  = out_q.leading_spaces;
  assign out_o.first_non_space = out_q.first_non_space;
  assign out_o.blank_line      = out_q.blank_line;
  assign out_o.horizontal_rule = out_q.horizontal_rule;

  a_stall_only_on_eol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_vld && !take |-> item.end_of_line && out_vld_q && !out_o.ready)
    else $error("input word stalled without a pending result");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_vld_q)
    else $error("result not presented after end of line");

  a_drain_clears_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_o.ready && !load |=> !out_vld_q)
    else $error("result word repeated after being taken");

endmodule
